>>> design/parallel_port_epp_controller_top_defines.svh
// Assertion macros used by the port-level checker of the parallel port controller.
`ifndef PARALLEL_PORT_EPP_CONTROLLER_TOP_DEFINES_SVH
`define PARALLEL_PORT_EPP_CONTROLLER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define PPEPP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define PPEPP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/ppepp_pkg.sv
// Package with codes, types and constants of the parallel port controller.
package ppepp_pkg;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [2:0] REG_DATA     = 3'd0;
  localparam logic [2:0] REG_STATUS   = 3'd1;
  localparam logic [2:0] REG_CONTROL  = 3'd2;
  localparam logic [2:0] REG_EPP_ADDR = 3'd3;
  localparam logic [2:0] REG_EPP_DATA = 3'd4;

  localparam logic CFG_PORT_MODE  = 1'b0;
  localparam logic CFG_WAIT_LIMIT = 1'b1;

  localparam int unsigned CFG_DATA_W = 4;
  localparam logic [3:0] WAIT_LIMIT_RESET = 4'd10;

  localparam logic MODE_LEGACY = 1'b0;
  localparam logic MODE_EPP    = 1'b1;

  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0] reg_index;
    logic [7:0] write_value;
    logic       nbusy;
    logic       ack;
    logic       paper_empty;
    logic       select;
    logic       error;
    logic [7:0] data_in;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       read_done;
    logic [7:0] data_out;
    logic       data_drive;
    logic       nstrobe;
    logic       nlinefeed;
    logic       reset;
    logic       nselect;
    logic       cycle_busy;
  } result_t;

  typedef struct packed {
    logic                  we;
    logic                  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_t;

endpackage

>>> design/ppepp_core.sv
// Register file, EPP cycle control and result formation of the parallel port.
module ppepp_core (
  input  logic              clk,
  input  logic              rst_n,
  input  ppepp_pkg::cfg_t   cfg,
  input  logic              item_accept,
  input  ppepp_pkg::item_t  item,
  output ppepp_pkg::result_t result
);

  logic       mode_r, mode_nxt;
  logic [3:0] limit_r, limit_nxt;
  logic [5:0] ctrl_r, ctrl_nxt;
  logic [7:0] latch_r, latch_nxt;
  logic [7:0] pin_r, pin_nxt;
  logic       drive_r, drive_nxt;
  logic [3:0] pins_r, pins_nxt;
  logic       tmo_r, tmo_nxt;
  logic       active_r, active_nxt;
  logic       is_read_r, is_read_nxt;
  logic       is_addr_r, is_addr_nxt;
  logic [3:0] wait_r, wait_nxt;
  logic [7:0] rdata;
  logic       rdone;
  logic       data_is_out;
  logic       is_addr;
  logic       finish;
  logic       ok;

  assign data_is_out = (mode_r == ppepp_pkg::MODE_LEGACY) || !ctrl_r[5];
  assign is_addr     = (item.reg_index == ppepp_pkg::REG_EPP_ADDR);

  always_comb begin
    mode_nxt    = mode_r;
    limit_nxt   = limit_r;
    ctrl_nxt    = ctrl_r;
    latch_nxt   = latch_r;
    pin_nxt     = pin_r;
    drive_nxt   = drive_r;
    pins_nxt    = pins_r;
    tmo_nxt     = tmo_r;
    active_nxt  = active_r;
    is_read_nxt = is_read_r;
    is_addr_nxt = is_addr_r;
    wait_nxt    = wait_r;
    rdata       = 8'd0;
    rdone       = 1'b0;
    finish      = 1'b0;
    ok          = 1'b0;
    if (cfg.we) begin
      if (cfg.index == ppepp_pkg::CFG_PORT_MODE) begin
        if (cfg.data[0] != mode_r) begin
          mode_nxt = cfg.data[0];
          if (!active_r) begin
            drive_nxt = (cfg.data[0] == ppepp_pkg::MODE_LEGACY) || !ctrl_r[5];
          end
        end
      end else begin
        limit_nxt = cfg.data;
      end
    end else if (item_accept) begin
      if (item.cmd == ppepp_pkg::CMD_TICK) begin
        if (active_r) begin
          if (item.nbusy) begin
            finish = 1'b1;
            ok     = 1'b1;
          end else if (wait_r <= 4'd1) begin
            finish = 1'b1;
          end else begin
            wait_nxt = wait_r - 4'd1;
          end
          if (finish) begin
            if (!ok) begin
              tmo_nxt = 1'b1;
            end
            if (is_read_r) begin
              rdone = 1'b1;
              if (ok) begin
                rdata       = item.data_in;
                ctrl_nxt[5] = 1'b1;
              end
            end
            wait_nxt    = 4'd0;
            active_nxt  = 1'b0;
            pins_nxt[1] = 1'b1;
            pins_nxt[3] = 1'b1;
            if (!is_read_r) begin
              pins_nxt[0] = 1'b1;
              drive_nxt   = !ctrl_r[5];
            end
          end
        end
      end else if ((item.cmd == ppepp_pkg::CMD_WRITE) && !active_r) begin
        case (item.reg_index)
          ppepp_pkg::REG_DATA: begin
            if (data_is_out) begin
              pin_nxt   = item.write_value;
              latch_nxt = item.write_value;
            end
          end
          ppepp_pkg::REG_CONTROL: begin
            if (mode_r == ppepp_pkg::MODE_LEGACY) begin
              ctrl_nxt = {1'b0, item.write_value[4:0]};
            end else begin
              ctrl_nxt  = item.write_value[5:0];
              drive_nxt = !item.write_value[5];
            end
            pins_nxt = {~item.write_value[3], item.write_value[2],
                        ~item.write_value[1], ~item.write_value[0]};
          end
          ppepp_pkg::REG_EPP_ADDR, ppepp_pkg::REG_EPP_DATA: begin
            if (mode_r == ppepp_pkg::MODE_EPP) begin
              if (item.nbusy) begin
                tmo_nxt = 1'b1;
              end else begin
                active_nxt  = 1'b1;
                is_read_nxt = 1'b0;
                is_addr_nxt = is_addr;
                wait_nxt    = (limit_r == 4'd0) ? 4'd1 : limit_r;
                drive_nxt   = 1'b1;
                pin_nxt     = item.write_value;
                pins_nxt    = {!is_addr, pins_r[2], is_addr, 1'b0};
              end
            end
          end
          default: begin
          end
        endcase
      end else if ((item.cmd == ppepp_pkg::CMD_READ) && !active_r) begin
        case (item.reg_index)
          ppepp_pkg::REG_DATA: begin
            rdone = 1'b1;
            rdata = data_is_out ? latch_r : item.data_in;
          end
          ppepp_pkg::REG_STATUS: begin
            rdone   = 1'b1;
            rdata   = {~item.nbusy, item.ack, item.paper_empty, item.select, item.error,
                       2'b00, tmo_r};
            tmo_nxt = 1'b0;
          end
          ppepp_pkg::REG_CONTROL: begin
            rdone = 1'b1;
            rdata = {2'b00, ctrl_r};
          end
          ppepp_pkg::REG_EPP_ADDR, ppepp_pkg::REG_EPP_DATA: begin
            if (item.nbusy) begin
              tmo_nxt = 1'b1;
              rdone   = 1'b1;
            end else begin
              active_nxt  = 1'b1;
              is_read_nxt = 1'b1;
              is_addr_nxt = is_addr;
              wait_nxt    = (limit_r == 4'd0) ? 4'd1 : limit_r;
              drive_nxt   = 1'b0;
              pins_nxt    = {!is_addr, pins_r[2], is_addr, 1'b1};
            end
          end
          default: begin
            rdone = 1'b1;
          end
        endcase
      end
    end
  end

  always_comb begin
    result.read_data  = rdata;
    result.read_done  = rdone;
    result.data_out   = drive_nxt ? pin_nxt : 8'd0;
    result.data_drive = drive_nxt;
    result.nstrobe    = pins_nxt[0];
    result.nlinefeed  = pins_nxt[1];
    result.reset      = pins_nxt[2];
    result.nselect    = pins_nxt[3];
    result.cycle_busy = active_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= ppepp_pkg::MODE_LEGACY;
      limit_r   <= ppepp_pkg::WAIT_LIMIT_RESET;
      ctrl_r    <= '0;
      latch_r   <= '0;
      pin_r     <= '0;
      drive_r   <= 1'b0;
      pins_r    <= '0;
      tmo_r     <= 1'b0;
      active_r  <= 1'b0;
      is_read_r <= 1'b0;
      is_addr_r <= 1'b0;
      wait_r    <= '0;
    end else begin
      mode_r    <= mode_nxt;
      limit_r   <= limit_nxt;
      ctrl_r    <= ctrl_nxt;
      latch_r   <= latch_nxt;
      pin_r     <= pin_nxt;
      drive_r   <= drive_nxt;
      pins_r    <= pins_nxt;
      tmo_r     <= tmo_nxt;
      active_r  <= active_nxt;
      is_read_r <= is_read_nxt;
      is_addr_r <= is_addr_nxt;
      wait_r    <= wait_nxt;
    end
  end

endmodule

>>> design/ppepp_skid.sv
// Two-entry result buffer that decouples the result channel from the core.
module ppepp_skid (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ppepp_pkg::result_t push_data,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output ppepp_pkg::result_t head_data
);

  logic               main_valid_r, main_valid_nxt;
  logic               skid_valid_r, skid_valid_nxt;
  ppepp_pkg::result_t main_r, main_nxt;
  ppepp_pkg::result_t skid_r, skid_nxt;
  logic               taken;

  assign taken     = main_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign head_data = main_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (push) begin
      if (!main_valid_r || taken) begin
        main_nxt       = push_data;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (taken) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        main_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

>>> design/parallel_port_epp_controller_top.sv
// Top level of the parallel port controller with legacy and EPP modes.
// The port takes one register access or microsecond tick per cycle while in_stall is low
// and returns one registered result for each; the register update and result are formed in a
// single pass of decode logic, and a two-entry result buffer lets in_stall rise only when
// both entries hold results that the consumer has not yet taken.
module parallel_port_epp_controller_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [3:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_cmd,
  input  logic [2:0] in_reg_index,
  input  logic [7:0] in_write_value,
  input  logic       in_nbusy_in,
  input  logic       in_ack_in,
  input  logic       in_paper_out_in,
  input  logic       in_select_in,
  input  logic       in_error_in,
  input  logic [7:0] in_data_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_data,
  output logic       out_read_done,
  output logic [7:0] out_data_out,
  output logic       out_data_drive,
  output logic       out_nstrobe_out,
  output logic       out_nlinefeed_out,
  output logic       out_reset_out,
  output logic       out_nselect_out,
  output logic       out_cycle_busy
);

  ppepp_pkg::cfg_t    cfg;
  ppepp_pkg::item_t   item;
  ppepp_pkg::result_t core_result;
  ppepp_pkg::result_t out_result;
  logic               full;
  logic               accept;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  assign item.cmd         = in_cmd;
  assign item.reg_index   = in_reg_index;
  assign item.write_value = in_write_value;
  assign item.nbusy       = in_nbusy_in;
  assign item.ack         = in_ack_in;
  assign item.paper_empty = in_paper_out_in;
  assign item.select      = in_select_in;
  assign item.error       = in_error_in;
  assign item.data_in     = in_data_in;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  ppepp_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .item_accept (accept),
    .item        (item),
    .result      (core_result)
  );

  ppepp_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (core_result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head_data (out_result)
  );

  assign out_read_data     = out_result.read_data;
  assign out_read_done     = out_result.read_done;
  assign out_data_out      = out_result.data_out;
  assign out_data_drive    = out_result.data_drive;
  assign out_nstrobe_out   = out_result.nstrobe;
  assign out_nlinefeed_out = out_result.nlinefeed;
  assign out_reset_out     = out_result.reset;
  assign out_nselect_out   = out_result.nselect;
  assign out_cycle_busy    = out_result.cycle_busy;

endmodule

>>> design/ppepp_checker.sv
// Port-level assertion checker for the parallel port controller, bound to the top level.
`include "parallel_port_epp_controller_top_defines.svh"

module ppepp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_read_data,
  input logic       out_read_done,
  input logic [7:0] out_data_out,
  input logic       out_data_drive,
  input logic       out_nstrobe_out,
  input logic       out_nlinefeed_out,
  input logic       out_reset_out,
  input logic       out_nselect_out,
  input logic       out_cycle_busy
);

  logic [22:0] res_bus;

  assign res_bus = {out_read_data, out_read_done, out_data_out, out_data_drive, out_nstrobe_out,
                    out_nlinefeed_out, out_reset_out, out_nselect_out, out_cycle_busy};

  `PPEPP_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(res_bus), "Stall broken.")
  `PPEPP_ASSERT_NOW(a_rdata, out_valid && !out_read_done, out_read_data == 8'd0, "Stray read data.")
  `PPEPP_ASSERT_NOW(a_dout, out_valid && !out_data_drive, out_data_out == 8'd0, "Stray pin data.")
  `PPEPP_ASSERT_NOW(a_done_idle, out_valid && out_read_done, !out_cycle_busy, "Open cycle on read.")

endmodule

bind parallel_port_epp_controller_top ppepp_checker u_checker (.*);
